@@ design/assert_macros.svh @@
// Assertion helpers included by the top-level hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define MD5SH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("md5 hasher check failed");

// Check that a condition never holds outside of reset.
`define MD5SH_NEVER(lbl, cond) \
	`MD5SH_ASSERT(lbl, !(cond))

`endif

@@ design/md5sh_pkg.sv @@
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round tables of the streaming MD5 hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

	localparam int WordW   = 32;
	localparam int BlkAddrW = 4;

	localparam logic [WordW-1:0] InitA = 32'h67452301;
	localparam logic [WordW-1:0] InitB = 32'hEFCDAB89;
	localparam logic [WordW-1:0] InitC = 32'h98BADCFE;
	localparam logic [WordW-1:0] InitD = 32'h10325476;

	localparam logic [5:0] LastRound = 6'd63;
	localparam logic [3:0] LastWord  = 4'd15;
	localparam logic [3:0] LenLoWord = 4'd14;
	localparam logic [7:0] PadByte   = 8'h80;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_item;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} result_t;

	// Block memory write port.
	typedef struct packed {
		logic                we;
		logic [BlkAddrW-1:0] addr;
		logic [WordW-1:0]    data;
	} mem_wr_t;

	// Working registers A, B, C, D of the rounds.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} round_regs_t;

	// Message word index used by round n.
	function automatic logic [3:0] msg_index(input logic [5:0] n);
		logic [7:0] k;
		begin
			case (n[5:4])
				2'd0: k = {2'b00, n};
				2'd1: k = 8'(5 * n + 1);
				2'd2: k = 8'(3 * n + 5);
				default: k = 8'(7 * n);
			endcase
			return k[3:0];
		end
	endfunction

	// Left rotation amount of round n.
	function automatic logic [4:0] rot_amount(input logic [5:0] n);
		logic [4:0] s;
		begin
			case ({n[5:4], n[1:0]})
				4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
				4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
				4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

	// Sine-derived additive constant of round n.
	function automatic logic [31:0] sine_const(input logic [5:0] n);
		logic [31:0] t;
		begin
			case (n)
				6'd0: t = 32'hD76AA478;  6'd1: t = 32'hE8C7B756;
				6'd2: t = 32'h242070DB;  6'd3: t = 32'hC1BDCEEE;
				6'd4: t = 32'hF57C0FAF;  6'd5: t = 32'h4787C62A;
				6'd6: t = 32'hA8304613;  6'd7: t = 32'hFD469501;
				6'd8: t = 32'h698098D8;  6'd9: t = 32'h8B44F7AF;
				6'd10: t = 32'hFFFF5BB1; 6'd11: t = 32'h895CD7BE;
				6'd12: t = 32'h6B901122; 6'd13: t = 32'hFD987193;
				6'd14: t = 32'hA679438E; 6'd15: t = 32'h49B40821;
				6'd16: t = 32'hF61E2562; 6'd17: t = 32'hC040B340;
				6'd18: t = 32'h265E5A51; 6'd19: t = 32'hE9B6C7AA;
				6'd20: t = 32'hD62F105D; 6'd21: t = 32'h02441453;
				6'd22: t = 32'hD8A1E681; 6'd23: t = 32'hE7D3FBC8;
				6'd24: t = 32'h21E1CDE6; 6'd25: t = 32'hC33707D6;
				6'd26: t = 32'hF4D50D87; 6'd27: t = 32'h455A14ED;
				6'd28: t = 32'hA9E3E905; 6'd29: t = 32'hFCEFA3F8;
				6'd30: t = 32'h676F02D9; 6'd31: t = 32'h8D2A4C8A;
				6'd32: t = 32'hFFFA3942; 6'd33: t = 32'h8771F681;
				6'd34: t = 32'h6D9D6122; 6'd35: t = 32'hFDE5380C;
				6'd36: t = 32'hA4BEEA44; 6'd37: t = 32'h4BDECFA9;
				6'd38: t = 32'hF6BB4B60; 6'd39: t = 32'hBEBFBC70;
				6'd40: t = 32'h289B7EC6; 6'd41: t = 32'hEAA127FA;
				6'd42: t = 32'hD4EF3085; 6'd43: t = 32'h04881D05;
				6'd44: t = 32'hD9D4D039; 6'd45: t = 32'hE6DB99E5;
				6'd46: t = 32'h1FA27CF8; 6'd47: t = 32'hC4AC5665;
				6'd48: t = 32'hF4292244; 6'd49: t = 32'h432AFF97;
				6'd50: t = 32'hAB9423A7; 6'd51: t = 32'hFC93A039;
				6'd52: t = 32'h655B59C3; 6'd53: t = 32'h8F0CCC92;
				6'd54: t = 32'hFFEFF47D; 6'd55: t = 32'h85845DD1;
				6'd56: t = 32'h6FA87E4F; 6'd57: t = 32'hFE2CE6E0;
				6'd58: t = 32'hA3014314; 6'd59: t = 32'h4E0811A1;
				6'd60: t = 32'hF7537E82; 6'd61: t = 32'hBD3AF235;
				6'd62: t = 32'h2AD7D2BB; default: t = 32'hEB86D391;
			endcase
			return t;
		end
	endfunction

endpackage

@@ design/md5sh_blkmem.sv @@
// ----------------------------------------------------------------------------
// md5sh_blkmem
// 16 x 32 block buffer, one write port and one registered read port.
// ----------------------------------------------------------------------------
module md5sh_blkmem import md5sh_pkg::*; (
	input  logic                clk,
	input  mem_wr_t             wr,
	input  logic [BlkAddrW-1:0] raddr,
	output logic [WordW-1:0]    rdata
);

	logic [WordW-1:0] mem [2**BlkAddrW];

	// Write on enable, read every cycle into the registered read data.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/md5sh_round.sv @@
// ----------------------------------------------------------------------------
// md5sh_round
// One MD5 compression round on the working registers.
// ----------------------------------------------------------------------------
module md5sh_round import md5sh_pkg::*; (
	input  round_regs_t      cur,
	input  logic [WordW-1:0] msg,
	input  logic [5:0]       n,
	output round_regs_t      nxt
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [4:0]  s;
	logic [63:0] dbl;

	// Pick the group's boolean function.
	always_comb begin
		case (n[5:4])
			2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
			2'd2: f = cur.b ^ cur.c ^ cur.d;
			default: f = cur.c ^ (cur.b | ~cur.d);
		endcase
	end

	// Add, rotate and shift the registers along.
	assign sum = f + cur.a + msg + sine_const(n);
	assign s   = rot_amount(n);
	assign dbl = {sum, sum} << s;

	assign nxt.a = cur.d;
	assign nxt.b = cur.b + dbl[63:32];
	assign nxt.c = cur.b;
	assign nxt.d = cur.c;

endmodule

@@ design/md5_stream_hasher_top.sv @@
// Sequence: an item that fills a block is followed by its compression;
//   a last item pads (3 to 18 word writes, one or two compressions) and then
//   offers four digest transactions, one per cycle when not stalled.
// Throughput: one item per cycle until a block fills or a last item comes,
//   then compression, one round per cycle reading the block memory port.
// Reset: chaining words take the initial values, fill and length clear.
// ----------------------------------------------------------------------------
// md5_stream_hasher_top
// Streaming MD5 hasher: packs bytes into a block memory, compresses, pads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module md5_stream_hasher_top import md5sh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    digest_valid,
	input  logic    digest_stall,
	output result_t digest
);

	typedef enum logic [2:0] {
		IDLE, PAD80, PAD, CPRE, CRND, CFIN, OUT
	} state_t;

	state_t          state_q;
	round_regs_t     chain_q, regs_q, regs_nxt;
	logic [5:0]      fill_q, rnd_q;
	logic [63:0]     msg_q;
	logic [31:0]     acc_q;
	logic [3:0]      pw_q;
	logic            last_q, pad_q, lenok_q, final_q;
	logic [1:0]      idx_q;

	mem_wr_t         wr;
	logic [3:0]      raddr;
	logic [31:0]     rdata;

	logic            accept;
	logic [2:0]      cnt;
	logic [2:0]      sum_b;
	logic [31:0]     dmask, dm;
	logic [63:0]     comb;
	logic            complete;
	logic [5:0]      fill_new;

	md5sh_blkmem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5sh_round u_round (
		.cur (regs_q),
		.msg (rdata),
		.n   (rnd_q),
		.nxt (regs_nxt)
	);

	assign item_stall = (state_q != IDLE);
	assign accept     = item_valid && !item_stall;

	// Clamp the byte count and merge the new bytes behind the partial word.
	always_comb begin
		cnt = (item.byte_count > 3'd4) ? 3'd4 : item.byte_count;
		case (cnt)
			3'd0: dmask = 32'h0000_0000;
			3'd1: dmask = 32'h0000_00FF;
			3'd2: dmask = 32'h0000_FFFF;
			3'd3: dmask = 32'h00FF_FFFF;
			default: dmask = 32'hFFFF_FFFF;
		endcase
		dm       = item.data_word & dmask;
		comb     = {32'b0, acc_q} | ({32'b0, dm} << {fill_q[1:0], 3'b000});
		sum_b    = {1'b0, fill_q[1:0]} + cnt;
		complete = sum_b[2];
		fill_new = fill_q + {3'b000, cnt};
	end

	// Drive the memory write port by state.
	always_comb begin
		wr = '0;
		unique case (state_q)
			IDLE: begin
				wr.we   = accept && complete;
				wr.addr = fill_q[5:2];
				wr.data = comb[31:0];
			end
			PAD80: begin
				wr.we   = 1'b1;
				wr.addr = fill_q[5:2];
				wr.data = acc_q | ({24'b0, PadByte} << {fill_q[1:0], 3'b000});
			end
			PAD: begin
				wr.we   = 1'b1;
				wr.addr = pw_q;
				if (lenok_q && pw_q == LenLoWord) begin
					wr.data = {msg_q[28:0], 3'b000};
				end else if (lenok_q && pw_q == LastWord) begin
					wr.data = msg_q[60:29];
				end else begin
					wr.data = '0;
				end
			end
			default: wr = '0;
		endcase
	end

	// Fetch one round ahead of use.
	always_comb begin
		if (state_q == CRND) begin
			raddr = msg_index(rnd_q + 6'd1);
		end else begin
			raddr = msg_index(6'd0);
		end
	end

	// Sequence absorb, padding, compression and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			chain_q <= {InitA, InitB, InitC, InitD};
			regs_q  <= '0;
			fill_q  <= '0;
			msg_q   <= '0;
			acc_q   <= '0;
			rnd_q   <= '0;
			pw_q    <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			lenok_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						fill_q <= fill_new;
						msg_q  <= msg_q + {61'b0, cnt};
						acc_q  <= complete ? comb[63:32] : comb[31:0];
						last_q <= item.last_item;
						pad_q  <= 1'b0;
						if (complete && fill_q[5:2] == LastWord) begin
							state_q <= CPRE;
						end else if (item.last_item) begin
							state_q <= PAD80;
						end
					end
				end
				PAD80: begin
					acc_q   <= '0;
					lenok_q <= (fill_q[5:2] < LenLoWord);
					pad_q   <= 1'b1;
					if (fill_q[5:2] == LastWord) begin
						final_q <= 1'b0;
						state_q <= CPRE;
					end else begin
						pw_q    <= fill_q[5:2] + 4'd1;
						state_q <= PAD;
					end
				end
				PAD: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == LastWord) begin
						final_q <= lenok_q;
						state_q <= CPRE;
					end
				end
				CPRE: begin
					regs_q  <= chain_q;
					rnd_q   <= '0;
					state_q <= CRND;
				end
				CRND: begin
					regs_q <= regs_nxt;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == LastRound) begin
						state_q <= CFIN;
					end
				end
				CFIN: begin
					chain_q.a <= chain_q.a + regs_q.a;
					chain_q.b <= chain_q.b + regs_q.b;
					chain_q.c <= chain_q.c + regs_q.c;
					chain_q.d <= chain_q.d + regs_q.d;
					rnd_q     <= '0;
					if (pad_q) begin
						if (final_q) begin
							idx_q   <= '0;
							state_q <= OUT;
						end else begin
							pw_q    <= '0;
							lenok_q <= 1'b1;
							state_q <= PAD;
						end
					end else if (last_q) begin
						state_q <= PAD80;
					end else begin
						state_q <= IDLE;
					end
				end
				OUT: begin
					if (!digest_stall) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							chain_q <= {InitA, InitB, InitC, InitD};
							fill_q  <= '0;
							msg_q   <= '0;
							acc_q   <= '0;
							last_q  <= 1'b0;
							pad_q   <= 1'b0;
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Present the digest words from the chaining registers.
	always_comb begin
		case (idx_q)
			2'd0: digest.digest_word = chain_q.a;
			2'd1: digest.digest_word = chain_q.b;
			2'd2: digest.digest_word = chain_q.c;
			default: digest.digest_word = chain_q.d;
		endcase
		digest.word_number = idx_q;
		digest.last_word   = (idx_q == 2'd3);
	end
	assign digest_valid = (state_q == OUT);

	`MD5SH_NEVER(a_out_blocks_in, digest_valid && !item_stall)
	`MD5SH_ASSERT(a_fin_after_last_round, (state_q == CFIN) |-> ($past(rnd_q) == LastRound))
	`MD5SH_NEVER(a_no_write_in_rounds, (state_q == CRND) && wr.we)

endmodule

@@ verif/md5_stream_hasher_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_top_tb
// Drives byte-granular messages into the MD5 hasher with random idle and
// stall bursts, predicts each digest in a behavioral model and checks every
// digest transaction against it in order.
// ----------------------------------------------------------------------------
module md5_stream_hasher_top_tb;
	import md5sh_pkg::*;

	localparam int NumRandom = 105;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    digest_valid;
	logic    digest_stall;
	result_t digest;

	md5_stream_hasher_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	// Predictor state
	logic [31:0] hash_chain [4];
	logic [31:0] hash_block [16];
	logic [5:0]  hash_fill;
	logic [63:0] hash_len;
	result_t     digest_queue [$];
	int          mismatches;
	bit          quiet;

	// Directed stimulus with known digests where the message is a classic one
	typedef struct {
		item_t       it;
		bit          known;
		logic [31:0] digest_a;
	} dir_row_t;
	dir_row_t dir_rows [$];

	localparam logic [31:0] SineTab [64] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
		32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
		32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
		32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
		32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
		32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};

	localparam int Shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	task automatic hash_reset();
		hash_chain = '{InitA, InitB, InitC, InitD};
		for (int i = 0; i < 16; i++) hash_block[i] = '0;
		hash_fill = '0;
		hash_len  = '0;
	endtask

	// Run the 64 rounds over the current block and fold into the chain
	task automatic hash_compress();
		logic [31:0] a, b, c, d, f, sum, tmp;
		int k, g;
		a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
		for (int n = 0; n < 64; n++) begin
			g = n / 16;
			case (g)
				0: begin f = (b & c) | (~b & d); k = n; end
				1: begin f = (b & d) | (c & ~d); k = 5 * n + 1; end
				2: begin f = b ^ c ^ d; k = 3 * n + 5; end
				default: begin f = c ^ (b | ~d); k = 7 * n; end
			endcase
			sum = f + a + hash_block[k % 16] + SineTab[n];
			tmp = d; d = c; c = b;
			b = b + ((sum << Shifts[g * 4 + n % 4]) | (sum >> (32 - Shifts[g * 4 + n % 4])));
			a = tmp;
		end
		hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
	endtask

	task automatic hash_byte(input logic [7:0] v);
		hash_block[hash_fill[5:2]][hash_fill[1:0] * 8 +: 8] = v;
		hash_fill = hash_fill + 6'd1;
		if (hash_fill == 6'd0) hash_compress();
	endtask

	// Absorb one transaction; on the last one queue the four digest words
	task automatic hash_item(input item_t it);
		int cnt;
		logic [63:0] bits;
		result_t r;
		cnt = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
		for (int i = 0; i < cnt; i++) hash_byte(it.data_word[i * 8 +: 8]);
		hash_len += 64'(cnt);
		if (it.last_item) begin
			bits = hash_len << 3;
			hash_byte(PadByte);
			while (hash_fill != 6'd56) hash_byte(8'h00);
			for (int i = 0; i < 8; i++) hash_byte(bits[i * 8 +: 8]);
			for (int i = 0; i < 4; i++) begin
				r.digest_word = hash_chain[i];
				r.word_number = 2'(i);
				r.last_word   = (i == 3);
				digest_queue.push_back(r);
			end
			hash_chain = '{InitA, InitB, InitC, InitD};
			hash_fill = '0;
			hash_len  = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Check each digest transaction against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && digest_valid && !digest_stall) begin
			if (digest_queue.size() == 0) begin
				report_mismatch("unexpected digest", digest.digest_word, '0);
			end else begin
				e = digest_queue.pop_front();
				if (digest.digest_word !== e.digest_word)
					report_mismatch("digest_word", digest.digest_word, e.digest_word);
				if (digest.word_number !== e.word_number)
					report_mismatch("word_number", 32'(digest.word_number), 32'(e.word_number));
				if (digest.last_word !== e.last_word)
					report_mismatch("last_word", 32'(digest.last_word), 32'(e.last_word));
			end
		end
	end

	// Stall the digest side in random bursts
	initial begin
		int gap;
		digest_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 5);
				digest_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			digest_stall <= 1'b0;
		end
	end

	// Present one transaction and hold it until accepted
	task automatic send_item(input item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		hash_item(it);
	endtask

	function automatic item_t mk(input logic [31:0] w, input logic [2:0] c, input logic l);
		item_t it;
		it.data_word = w; it.byte_count = c; it.last_item = l;
		return it;
	endfunction

	function automatic dir_row_t row(input item_t it, input bit known, input logic [31:0] a);
		dir_row_t r;
		r.it = it; r.known = known; r.digest_a = a;
		return r;
	endfunction

	initial begin
		item_t it;
		int msg_words, wait_cnt;
		mismatches = 0;
		quiet      = 1'b0;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		hash_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message: digest word A is d41d8cd9 in little-endian word order
		dir_rows.push_back(row(mk(32'hFFFF_FFFF, 3'd0, 1'b1), 1, 32'hD98C1DD4));
		// "abc": digest word A 98500190 byte-reversed
		dir_rows.push_back(row(mk(32'hFF63_6261, 3'd3, 1'b1), 1, 32'h98500190));
		// Count above four, short word mid-stream, extremes of the data
		dir_rows.push_back(row(mk(32'hFFFF_FFFF, 3'd7, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'h0000_0000, 3'd5, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'hA5A5_A5A5, 3'd1, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'h5A5A_5A5A, 3'd2, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'h1234_5678, 3'd0, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'hDEAD_BEEF, 3'd6, 1'b1), 0, '0));
		// Fill exactly to the pad boundary: 14 words then one of 3 bytes
		for (int i = 0; i < 14; i++)
			dir_rows.push_back(row(mk($urandom, 3'd4, 1'b0), 0, '0));
		dir_rows.push_back(row(mk(32'hFFFF_FFFF, 3'd3, 1'b1), 0, '0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].known && dir_rows[i].it.last_item) begin
				send_item(dir_rows[i].it);
				if (digest_queue[$ - 3].digest_word !== dir_rows[i].digest_a)
					report_mismatch("known digest", digest_queue[$ - 3].digest_word,
						dir_rows[i].digest_a);
			end else begin
				send_item(dir_rows[i].it);
			end
		end

		// Random messages: mostly full words, sometimes short ones
		for (int n = 0; n < NumRandom; ) begin
			msg_words = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 34)
				: $urandom_range(0, 6);
			if (n > NumRandom - 20) quiet = 1'b1;
			for (int w = 0; w <= msg_words; w++) begin
				it.data_word  = $urandom;
				it.byte_count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
				it.last_item  = (w == msg_words);
				send_item(it);
				n++;
			end
		end
		item_valid <= 1'b0;

		wait_cnt = 0;
		while (digest_queue.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (digest_queue.size() != 0)
			report_mismatch("digests never seen", 32'(digest_queue.size()), '0);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
